[hdl/motbl_pkg.sv]
// Package for the market order table engine: types, codes and table sizing.
// Depends on nothing; the top level imports it.
`default_nettype none
package motbl_pkg;

  localparam int unsigned ORDER_SLOTS = 4096;
  localparam int unsigned SLOT_AW = $clog2(ORDER_SLOTS);

  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_ATTR    = 3'd1;
  localparam logic [2:0] REQ_EXEC    = 3'd2;
  localparam logic [2:0] REQ_DELETE  = 3'd3;
  localparam logic [2:0] REQ_REPLACE = 3'd4;
  localparam logic [2:0] REQ_RESTORE = 3'd5;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_EXEC   = 2'd2;
  localparam logic [1:0] KIND_NOTICE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_REF  = 3'd1;
  localparam logic [2:0] ST_COLLISION = 3'd2;
  localparam logic [2:0] ST_ORPH_EXEC = 3'd3;
  localparam logic [2:0] ST_ORPH_DEL  = 3'd4;
  localparam logic [2:0] ST_ORPH_REPL = 3'd5;
  localparam logic [2:0] ST_CLAMPED   = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  localparam logic [7:0] TYPE_SPACE = 8'h20;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] order_ref;
    logic [63:0] replacement_ref;
    logic [15:0] book_index;
    logic [7:0]  group_index;
    logic        side_flag;
    logic [31:0] limit_price;
    logic [31:0] quantity;
    logic [7:0]  type_code;
    logic [63:0] match_ref;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  status_code;
    logic [15:0] out_book;
    logic [7:0]  out_group;
    logic        out_side;
    logic [31:0] out_price;
    logic [31:0] out_qty;
    logic        order_gone;
    logic [63:0] out_match;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [7:0]  type_code;
    logic        side;
    logic [7:0]  group;
    logic [15:0] book;
  } attr_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    attr_t       attrs;
    logic [31:0] price;
    logic [31:0] remaining;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_SCAN_LAST, S_EVAL,
    S_REMOVE, S_XREM, S_XREP, S_INSERT, S_NOTICE
  } state_e;

endpackage
`default_nettype wire

[hdl/motbl_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the order table.
`default_nettype none
module motbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[hdl/market_order_table_engine_unit.sv]
// Top level of the market order table engine: sequencer, scan compare unit.
// Depends on motbl_pkg and motbl_ram.
// After reset the table is cleared, one slot a cycle, while busy is high.
// A message scans every slot of the table, then produces its results in order;
// a replace that finds its order scans twice, and an add with order number zero skips the scan.
// Each result shows in the cycle after its state; busy falls as the last result appears.
// The receiver cannot stall; each result is valid for exactly one cycle.
`default_nettype none
module market_order_table_engine_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire motbl_pkg::req_t req_i,
  output logic                 busy_o,
  output logic                 valid_o,
  output motbl_pkg::res_t      result_o
);
  import motbl_pkg::*;

  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(ORDER_SLOTS - 1);

  state_e state_q, state_d;
  req_t item_q, item_d;
  logic [SLOT_AW-1:0] cnt_q, cnt_d;
  logic rd_pend_q, rd_pend_d;
  logic match_q, match_d, free_q, free_d;
  logic [SLOT_AW-1:0] match_idx_q, match_idx_d, free_idx_q, free_idx_d;
  entry_t match_ent_q, match_ent_d;
  attr_t attrs_q, attrs_d;
  logic pass2_q, pass2_d;
  logic [2:0] notice_q, notice_d;
  res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic mem_we;
  logic [SLOT_AW-1:0] mem_waddr;
  entry_t mem_wdata, rd_ent;
  logic [$bits(entry_t)-1:0] rd_raw;

  logic [63:0] scan_key;
  logic [31:0] x_fill, x_rem;
  logic x_clamp, x_gone;
  logic tgt_ok;
  logic [SLOT_AW-1:0] tgt_idx;
  attr_t ins_attrs;

  motbl_ram #(.WIDTH($bits(entry_t)), .DEPTH(ORDER_SLOTS)) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(cnt_q),
    .rdata_o(rd_raw)
  );

  assign rd_ent = entry_t'(rd_raw);
  assign scan_key = pass2_q ? item_q.replacement_ref : item_q.order_ref;
  assign busy_o = (state_q != S_IDLE);
  assign valid_o = res_valid_q;
  assign result_o = res_q;

  always_comb begin
    x_clamp = item_q.quantity > match_ent_q.remaining;
    x_fill = x_clamp ? match_ent_q.remaining : item_q.quantity;
    x_rem = match_ent_q.remaining - x_fill;
    x_gone = (x_rem == 32'd0);
  end

  always_comb begin
    tgt_ok = 1'b0;
    tgt_idx = free_idx_q;
    if (item_q.req_type == REQ_RESTORE) begin
      if (match_q) begin
        tgt_ok = 1'b1;
        tgt_idx = match_idx_q;
      end else begin
        tgt_ok = free_q;
      end
    end else if (match_q) begin
      tgt_ok = 1'b1;
      tgt_idx = (free_q && free_idx_q < match_idx_q) ? free_idx_q : match_idx_q;
    end else begin
      tgt_ok = free_q;
    end
    if (pass2_q) begin
      ins_attrs = attrs_q;
    end else begin
      ins_attrs.book = item_q.book_index;
      ins_attrs.group = item_q.group_index;
      ins_attrs.side = item_q.side_flag;
      ins_attrs.type_code = (item_q.req_type == REQ_ADD) ? TYPE_SPACE : item_q.type_code;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (cnt_q == LAST_SLOT) state_d = S_IDLE;
      S_IDLE: begin
        if (start_i) begin
          case (req_i.req_type)
            REQ_ADD, REQ_ATTR: state_d = (req_i.order_ref == 64'd0) ? S_NOTICE : S_SCAN;
            REQ_EXEC, REQ_DELETE, REQ_REPLACE, REQ_RESTORE: state_d = S_SCAN;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: if (cnt_q == LAST_SLOT) state_d = S_SCAN_LAST;
      S_SCAN_LAST: state_d = S_EVAL;
      S_EVAL: begin
        case (item_q.req_type)
          REQ_ADD, REQ_ATTR: state_d = match_q ? S_REMOVE : S_INSERT;
          REQ_EXEC: state_d = match_q ? S_XREM : S_NOTICE;
          REQ_DELETE: state_d = match_q ? S_REMOVE : S_NOTICE;
          REQ_REPLACE: state_d = match_q ? S_REMOVE : (pass2_q ? S_INSERT : S_NOTICE);
          REQ_RESTORE: state_d = S_INSERT;
          default: state_d = S_IDLE;
        endcase
      end
      S_REMOVE: begin
        if (item_q.req_type == REQ_DELETE) state_d = S_IDLE;
        else if (item_q.req_type == REQ_REPLACE && !pass2_q) state_d = S_SCAN;
        else state_d = S_INSERT;
      end
      S_XREM: state_d = S_XREP;
      S_XREP, S_INSERT, S_NOTICE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    item_d = item_q;
    cnt_d = '0;
    rd_pend_d = (state_q == S_SCAN);
    match_d = match_q;
    free_d = free_q;
    match_idx_d = match_idx_q;
    free_idx_d = free_idx_q;
    match_ent_d = match_ent_q;
    attrs_d = attrs_q;
    pass2_d = pass2_q;
    notice_d = notice_q;
    if (state_q == S_CLEAR || state_q == S_SCAN) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (state_q == S_IDLE) begin
      item_d = req_i;
      match_d = 1'b0;
      free_d = 1'b0;
      pass2_d = 1'b0;
      notice_d = ST_ZERO_REF;
    end
    if (state_q == S_REMOVE && item_q.req_type == REQ_REPLACE && !pass2_q) begin
      match_d = 1'b0;
      free_d = 1'b0;
      pass2_d = 1'b1;
      attrs_d = match_ent_q.attrs;
    end
    if (state_q == S_EVAL) begin
      case (item_q.req_type)
        REQ_EXEC: notice_d = ST_ORPH_EXEC;
        REQ_DELETE: notice_d = ST_ORPH_DEL;
        default: notice_d = ST_ORPH_REPL;
      endcase
    end
    if (rd_pend_q) begin
      if (rd_ent.valid && rd_ent.key == scan_key && !match_q) begin
        match_d = 1'b1;
        match_idx_d = cnt_q - 1'b1;
        match_ent_d = rd_ent;
      end
      if (!rd_ent.valid && !free_q) begin
        free_d = 1'b1;
        free_idx_d = cnt_q - 1'b1;
      end
    end
  end

  always_comb begin
    res_d = '0;
    res_valid_d = 1'b0;
    mem_we = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = '0;
    unique case (state_q)
      S_CLEAR: mem_we = 1'b1;
      S_NOTICE: begin
        res_valid_d = 1'b1;
        res_d.result_kind = KIND_NOTICE;
        res_d.status_code = notice_q;
        res_d.last_of_run = 1'b1;
      end
      S_REMOVE: begin
        res_valid_d = 1'b1;
        res_d.result_kind = KIND_REMOVE;
        res_d.status_code = (item_q.req_type == REQ_DELETE ||
                             (item_q.req_type == REQ_REPLACE && !pass2_q)) ?
                            ST_OK : ST_COLLISION;
        res_d.out_book = match_ent_q.attrs.book;
        res_d.out_group = match_ent_q.attrs.group;
        res_d.out_side = match_ent_q.attrs.side;
        res_d.out_price = match_ent_q.price;
        res_d.out_qty = match_ent_q.remaining;
        res_d.order_gone = 1'b1;
        res_d.last_of_run = (item_q.req_type == REQ_DELETE);
        mem_we = 1'b1;
        mem_waddr = match_idx_q;
        mem_wdata = match_ent_q;
        mem_wdata.valid = 1'b0;
      end
      S_XREM, S_XREP: begin
        res_valid_d = 1'b1;
        res_d.result_kind = (state_q == S_XREM) ? KIND_REMOVE : KIND_EXEC;
        res_d.status_code = x_clamp ? ST_CLAMPED : ST_OK;
        res_d.out_book = match_ent_q.attrs.book;
        res_d.out_group = match_ent_q.attrs.group;
        res_d.out_side = match_ent_q.attrs.side;
        res_d.out_price = match_ent_q.price;
        res_d.out_qty = x_fill;
        res_d.order_gone = x_gone;
        res_d.out_match = (state_q == S_XREP) ? item_q.match_ref : 64'd0;
        res_d.last_of_run = (state_q == S_XREP);
        if (state_q == S_XREM) begin
          mem_we = 1'b1;
          mem_waddr = match_idx_q;
          mem_wdata = match_ent_q;
          mem_wdata.remaining = x_rem;
          mem_wdata.valid = !x_gone;
        end
      end
      S_INSERT: begin
        res_valid_d = 1'b1;
        res_d.last_of_run = 1'b1;
        if (!tgt_ok) begin
          res_d.result_kind = KIND_NOTICE;
          res_d.status_code = ST_FULL;
        end else begin
          res_d.result_kind = KIND_ADD;
          res_d.status_code = ST_OK;
          res_d.out_book = ins_attrs.book;
          res_d.out_group = ins_attrs.group;
          res_d.out_side = ins_attrs.side;
          res_d.out_price = item_q.limit_price;
          res_d.out_qty = item_q.quantity;
          mem_we = 1'b1;
          mem_waddr = tgt_idx;
          mem_wdata.valid = 1'b1;
          mem_wdata.key = scan_key;
          mem_wdata.attrs = ins_attrs;
          mem_wdata.price = item_q.limit_price;
          mem_wdata.remaining = item_q.quantity;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q <= '0;
      rd_pend_q <= 1'b0;
      res_valid_q <= 1'b0;
      match_q <= 1'b0;
      free_q <= 1'b0;
      pass2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      rd_pend_q <= rd_pend_d;
      res_valid_q <= res_valid_d;
      match_q <= match_d;
      free_q <= free_d;
      pass2_q <= pass2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    match_idx_q <= match_idx_d;
    free_idx_q <= free_idx_d;
    match_ent_q <= match_ent_d;
    attrs_q <= attrs_d;
    notice_q <= notice_d;
    res_q <= res_d;
  end

  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o)) else $error("result without a busy cycle");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we) else $error("table write while idle");
  a_notice_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.result_kind == KIND_NOTICE) |-> result_o.last_of_run)
    else $error("notice is not the final result");

endmodule
`default_nettype wire
